// ===== src/allocation_tracking_table_defines.svh =====
// ----------------------------------------------------------------------------
// Allocation tracking table - assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ALLOCATION_TRACKING_TABLE_DEFINES_SVH
`define ALLOCATION_TRACKING_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define ATT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// property checked on every clock edge, reset included
`define ATT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ATT_ASSERT(lbl, prop, msg)
`define ATT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/att_pkg.sv =====
// ----------------------------------------------------------------------------
// Allocation tracking table - package
// Shared widths, codes, state encoding and a helper function.
// ----------------------------------------------------------------------------
package att_pkg;

  // default sizing
  localparam int unsigned HashSetsDef = 256;
  localparam int unsigned SetWaysDef  = 4;
  localparam int unsigned AddrBitsDef = 48;

  // fixed field widths
  localparam int unsigned SIZE_W   = 40;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned BYTE_W   = 48;
  localparam int unsigned BKT_W    = 5;
  localparam int unsigned NBUCKETS = 27;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK          = 3'd0,
    STS_DISABLED    = 3'd1,
    STS_NULL        = 3'd2,
    STS_BELOW_MIN   = 3'd3,
    STS_DUPLICATE   = 3'd4,
    STS_NOT_TRACKED = 3'd5,
    STS_FULL        = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  // configuration register indexes
  localparam logic CFG_ENABLE   = 1'b0;
  localparam logic CFG_MIN_SIZE = 1'b1;

  // statistics update for one action
  typedef struct packed {
    logic              alloc_ok;
    logic              free_ok;
    logic              clear;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] freed_size;
    logic [BKT_W-1:0]  bucket;
  } stats_op_t;

  // log2 size bucket: 0 below 64, else msb - 5, capped at 26
  function automatic logic [BKT_W-1:0] bucket_of(input logic [SIZE_W-1:0] size);
    logic [5:0] msb;
    msb = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size[i]) msb = 6'(i);
    end
    if (size < SIZE_W'(64)) return '0;
    else if (msb >= 6'd31) return BKT_W'(NBUCKETS - 1);
    else return BKT_W'(msb - 6'd5);
  endfunction

endpackage

// ===== src/allocation_tracking_table.sv =====
// Flow: an accepted action executes in the EXEC state; done_o is registered from that state.
// The block is busy in EXEC and takes no new action until it is back in idle, set by the
// read-modify-write of one set row in the entry RAM (read in the accept cycle, compare and
// write back in the next). Reset: statistics clear at once; a clearing pass then zeroes the
// RAM, one set per cycle, through every set with busy high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// Allocation tracking table - top level
// Set-associative table of live allocations with saturating statistics.
// ----------------------------------------------------------------------------
`include "allocation_tracking_table_defines.svh"

module allocation_tracking_table #(
  parameter int unsigned HASH_SETS = att_pkg::HashSetsDef,
  parameter int unsigned SET_WAYS  = att_pkg::SetWaysDef,
  parameter int unsigned ADDR_BITS = att_pkg::AddrBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action_i,
  input  logic [ADDR_BITS-1:0]          address_i,
  input  logic [att_pkg::SIZE_W-1:0]    alloc_size_i,
  input  logic [att_pkg::BKT_W-1:0]     bucket_select_i,
  // result
  output logic                          done_o,
  output logic [att_pkg::STATUS_W-1:0]  status_o,
  output logic [att_pkg::CNT_W-1:0]     live_count_o,
  output logic [att_pkg::BYTE_W-1:0]    live_bytes_o,
  output logic [att_pkg::CNT_W-1:0]     peak_count_o,
  output logic [att_pkg::BYTE_W-1:0]    peak_bytes_o,
  output logic [att_pkg::CNT_W-1:0]     alloc_total_o,
  output logic [att_pkg::CNT_W-1:0]     free_total_o,
  output logic [att_pkg::BYTE_W-1:0]    bytes_total_o,
  output logic [att_pkg::CNT_W-1:0]     bucket_count_o,
  output logic [att_pkg::BYTE_W-1:0]    bucket_bytes_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [att_pkg::SIZE_W-1:0]    cfg_data_i
);

  localparam int unsigned SW     = att_pkg::SIZE_W;
  localparam int unsigned SetW   = $clog2(HASH_SETS);
  localparam int unsigned WayW   = 1 + ADDR_BITS + SW;
  localparam int unsigned RowW   = SET_WAYS * WayW;

  // -------------------------------------------------------------------------
  // configuration registers
  logic          enable_q;
  logic [SW-1:0] min_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      min_size_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == att_pkg::CFG_ENABLE) enable_q <= cfg_data_i[0];
      if (cfg_index_i == att_pkg::CFG_MIN_SIZE) min_size_q <= cfg_data_i;
    end
  end

  // -------------------------------------------------------------------------
  // control state
  att_pkg::fsm_e   state_q, state_d;
  logic [SetW-1:0] sweep_q;
  logic            accept;

  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      att_pkg::FSM_CLEAR: if (sweep_q == '1) state_d = att_pkg::FSM_IDLE;
      att_pkg::FSM_IDLE:  if (start) state_d = att_pkg::FSM_EXEC;
      att_pkg::FSM_EXEC:  state_d = att_pkg::FSM_IDLE;
      default:            state_d = att_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      att_pkg::FSM_IDLE: busy = 1'b0;
      default:           busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= att_pkg::FSM_CLEAR;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == att_pkg::FSM_CLEAR) sweep_q <= sweep_q + SetW'(1);
    end
  end

  // -------------------------------------------------------------------------
  // command capture and set hash
  logic [1:0]               action_q;
  logic [ADDR_BITS-1:0]     addr_q;
  logic [SW-1:0]            size_q;
  logic [att_pkg::BKT_W-1:0] sel_q;
  logic [SetW-1:0]          set_q, set_in;
  logic [63:0]              addr_ext;
  logic [63:0]              hash;

  assign addr_ext = 64'(address_i);
  assign hash     = addr_ext ^ (addr_ext >> 16);
  assign set_in   = hash[SetW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      addr_q   <= address_i;
      size_q   <= alloc_size_i;
      sel_q    <= bucket_select_i;
      set_q    <= set_in;
    end
  end

  // -------------------------------------------------------------------------
  // entry RAM, one row per set
  logic            ram_we;
  logic [SetW-1:0] ram_waddr;
  logic [RowW-1:0] ram_wdata, row_rd, row_new;

  att_ram #(
    .Width (RowW),
    .Depth (HASH_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (set_in),
    .rdata_o (row_rd)
  );

  // -------------------------------------------------------------------------
  // way compare on the row read back
  logic                 hit, has_free;
  logic [SET_WAYS-1:0]  hit_sel, free_sel;
  logic [SW-1:0]        hit_size;

  always_comb begin
    logic          w_valid;
    logic [ADDR_BITS-1:0] w_addr;
    hit      = 1'b0;
    has_free = 1'b0;
    hit_sel  = '0;
    free_sel = '0;
    hit_size = '0;
    for (int w = 0; w < SET_WAYS; w++) begin
      w_valid = row_rd[w*WayW + WayW - 1];
      w_addr  = row_rd[w*WayW + SW +: ADDR_BITS];
      if (w_valid) begin
        if (!hit && w_addr == addr_q) begin
          hit        = 1'b1;
          hit_sel[w] = 1'b1;
          hit_size   = row_rd[w*WayW +: SW];
        end
      end else if (!has_free) begin
        has_free    = 1'b1;
        free_sel[w] = 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // status decision
  att_pkg::status_e status;
  logic             alloc_ok, free_ok;

  always_comb begin
    status = att_pkg::STS_OK;
    case (att_pkg::action_e'(action_q))
      att_pkg::ACT_ALLOC: begin
        if (!enable_q) status = att_pkg::STS_DISABLED;
        else if (addr_q == '0) status = att_pkg::STS_NULL;
        else if (size_q < min_size_q) status = att_pkg::STS_BELOW_MIN;
        else if (hit) status = att_pkg::STS_DUPLICATE;
        else if (!has_free) status = att_pkg::STS_FULL;
      end
      att_pkg::ACT_FREE: begin
        if (!enable_q) status = att_pkg::STS_DISABLED;
        else if (addr_q == '0) status = att_pkg::STS_NULL;
        else if (!hit) status = att_pkg::STS_NOT_TRACKED;
      end
      default: status = att_pkg::STS_OK;
    endcase
  end

  assign alloc_ok = (action_q == att_pkg::ACT_ALLOC) && (status == att_pkg::STS_OK);
  assign free_ok  = (action_q == att_pkg::ACT_FREE) && (status == att_pkg::STS_OK);

  // row write back: insert into first free way or drop the hit way
  always_comb begin
    row_new = row_rd;
    for (int w = 0; w < SET_WAYS; w++) begin
      if (alloc_ok && free_sel[w]) row_new[w*WayW +: WayW] = {1'b1, addr_q, size_q};
      if (free_ok && hit_sel[w]) row_new[w*WayW + WayW - 1] = 1'b0;
    end
  end

  always_comb begin
    if (state_q == att_pkg::FSM_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_q == att_pkg::FSM_EXEC) && (alloc_ok || free_ok);
      ram_waddr = set_q;
      ram_wdata = row_new;
    end
  end

  // -------------------------------------------------------------------------
  // statistics
  att_pkg::stats_op_t          stats_op;
  logic                        exec;
  logic [att_pkg::CNT_W-1:0]   bkt_count;
  logic [att_pkg::BYTE_W-1:0]  bkt_bytes;

  assign exec = (state_q == att_pkg::FSM_EXEC);

  always_comb begin
    stats_op.alloc_ok   = alloc_ok;
    stats_op.free_ok    = free_ok;
    stats_op.clear      = (action_q == att_pkg::ACT_CLEAR);
    stats_op.size       = size_q;
    stats_op.freed_size = hit_size;
    stats_op.bucket     = att_pkg::bucket_of(size_q);
  end

  att_stats u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (exec),
    .op_i          (stats_op),
    .sel_i         (sel_q),
    .live_count_o  (live_count_o),
    .live_bytes_o  (live_bytes_o),
    .peak_count_o  (peak_count_o),
    .peak_bytes_o  (peak_bytes_o),
    .alloc_total_o (alloc_total_o),
    .free_total_o  (free_total_o),
    .bytes_total_o (bytes_total_o),
    .bkt_count_o   (bkt_count),
    .bkt_bytes_o   (bkt_bytes)
  );

  // -------------------------------------------------------------------------
  // result beat
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= exec;
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_o       <= status;
      bucket_count_o <= (action_q == att_pkg::ACT_READ) ? bkt_count : '0;
      bucket_bytes_o <= (action_q == att_pkg::ACT_READ) ? bkt_bytes : '0;
    end
  end

  assign done_o = done_q;

  // -------------------------------------------------------------------------
  // assertions
  `ATT_ASSERT(a_done_after_exec, done_o |-> $past(state_q == att_pkg::FSM_EXEC),
              "result beat without an executed action")
  `ATT_ASSERT(a_no_write_idle, ram_we |-> (state_q != att_pkg::FSM_IDLE),
              "entry RAM written while idle")
  `ATT_ASSERT(a_clear_busy, (state_q == att_pkg::FSM_CLEAR) |-> busy && !done_o,
              "action possible during clearing pass")
  `ATT_ASSERT(a_alloc_free_excl, exec |-> !(alloc_ok && free_ok),
              "allocate and free taken together")

endmodule

// ===== src/att_ram.sv =====
// ----------------------------------------------------------------------------
// Allocation tracking table - generic RAM
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module att_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/att_stats.sv =====
// ----------------------------------------------------------------------------
// Allocation tracking table - statistics
// Saturating counters, peaks and the log2 size histogram.
// ----------------------------------------------------------------------------
module att_stats (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          op_valid_i,
  input  att_pkg::stats_op_t            op_i,
  input  logic [att_pkg::BKT_W-1:0]     sel_i,
  output logic [att_pkg::CNT_W-1:0]     live_count_o,
  output logic [att_pkg::BYTE_W-1:0]    live_bytes_o,
  output logic [att_pkg::CNT_W-1:0]     peak_count_o,
  output logic [att_pkg::BYTE_W-1:0]    peak_bytes_o,
  output logic [att_pkg::CNT_W-1:0]     alloc_total_o,
  output logic [att_pkg::CNT_W-1:0]     free_total_o,
  output logic [att_pkg::BYTE_W-1:0]    bytes_total_o,
  output logic [att_pkg::CNT_W-1:0]     bkt_count_o,
  output logic [att_pkg::BYTE_W-1:0]    bkt_bytes_o
);

  localparam int unsigned CW = att_pkg::CNT_W;
  localparam int unsigned BW = att_pkg::BYTE_W;
  localparam int unsigned NB = att_pkg::NBUCKETS;

  logic [CW-1:0] live_count_q, live_count_d, peak_count_q, peak_count_d;
  logic [CW-1:0] alloc_total_q, alloc_total_d, free_total_q, free_total_d;
  logic [BW-1:0] live_bytes_q, live_bytes_d, peak_bytes_q, peak_bytes_d;
  logic [BW-1:0] bytes_total_q, bytes_total_d;
  logic [CW-1:0] hist_count_q [NB];
  logic [BW-1:0] hist_bytes_q [NB];
  logic [CW:0]   cnt_inc, live_inc, hcnt_inc;
  logic [BW:0]   bytes_inc, live_add, hbytes_inc;
  logic [BW-1:0] size_ext, freed_ext;

  assign size_ext  = BW'(op_i.size);
  assign freed_ext = BW'(op_i.freed_size);

  // saturating sums
  always_comb begin
    cnt_inc    = {1'b0, alloc_total_q} + (CW+1)'(1);
    live_inc   = {1'b0, live_count_q} + (CW+1)'(1);
    bytes_inc  = {1'b0, bytes_total_q} + {1'b0, size_ext};
    live_add   = {1'b0, live_bytes_q} + {1'b0, size_ext};
    hcnt_inc   = {1'b0, hist_count_q[op_i.bucket]} + (CW+1)'(1);
    hbytes_inc = {1'b0, hist_bytes_q[op_i.bucket]} + {1'b0, size_ext};
  end

  // counter next state
  always_comb begin
    live_count_d  = live_count_q;
    live_bytes_d  = live_bytes_q;
    peak_count_d  = peak_count_q;
    peak_bytes_d  = peak_bytes_q;
    alloc_total_d = alloc_total_q;
    free_total_d  = free_total_q;
    bytes_total_d = bytes_total_q;
    if (op_valid_i && op_i.alloc_ok) begin
      alloc_total_d = cnt_inc[CW] ? '1 : cnt_inc[CW-1:0];
      live_count_d  = live_inc[CW] ? '1 : live_inc[CW-1:0];
      bytes_total_d = bytes_inc[BW] ? '1 : bytes_inc[BW-1:0];
      live_bytes_d  = live_add[BW] ? '1 : live_add[BW-1:0];
      if (live_count_d > peak_count_q) peak_count_d = live_count_d;
      if (live_bytes_d > peak_bytes_q) peak_bytes_d = live_bytes_d;
    end else if (op_valid_i && op_i.free_ok) begin
      free_total_d = (free_total_q == '1) ? '1 : free_total_q + CW'(1);
      live_count_d = (live_count_q == '0) ? '0 : live_count_q - CW'(1);
      live_bytes_d = (freed_ext > live_bytes_q) ? '0 : live_bytes_q - freed_ext;
    end else if (op_valid_i && op_i.clear) begin
      live_count_d  = '0;
      live_bytes_d  = '0;
      peak_count_d  = '0;
      peak_bytes_d  = '0;
      alloc_total_d = '0;
      free_total_d  = '0;
      bytes_total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_count_q  <= '0;
      live_bytes_q  <= '0;
      peak_count_q  <= '0;
      peak_bytes_q  <= '0;
      alloc_total_q <= '0;
      free_total_q  <= '0;
      bytes_total_q <= '0;
    end else begin
      live_count_q  <= live_count_d;
      live_bytes_q  <= live_bytes_d;
      peak_count_q  <= peak_count_d;
      peak_bytes_q  <= peak_bytes_d;
      alloc_total_q <= alloc_total_d;
      free_total_q  <= free_total_d;
      bytes_total_q <= bytes_total_d;
    end
  end

  // histogram buckets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NB; i++) begin
        hist_count_q[i] <= '0;
        hist_bytes_q[i] <= '0;
      end
    end else if (op_valid_i && op_i.clear) begin
      for (int i = 0; i < NB; i++) begin
        hist_count_q[i] <= '0;
        hist_bytes_q[i] <= '0;
      end
    end else if (op_valid_i && op_i.alloc_ok) begin
      hist_count_q[op_i.bucket] <= hcnt_inc[CW] ? '1 : hcnt_inc[CW-1:0];
      hist_bytes_q[op_i.bucket] <= hbytes_inc[BW] ? '1 : hbytes_inc[BW-1:0];
    end
  end

  // bucket read, out of range reads zero
  always_comb begin
    bkt_count_o = '0;
    bkt_bytes_o = '0;
    if (sel_i < att_pkg::BKT_W'(NB)) begin
      bkt_count_o = hist_count_q[sel_i];
      bkt_bytes_o = hist_bytes_q[sel_i];
    end
  end

  assign live_count_o  = live_count_q;
  assign live_bytes_o  = live_bytes_q;
  assign peak_count_o  = peak_count_q;
  assign peak_bytes_o  = peak_bytes_q;
  assign alloc_total_o = alloc_total_q;
  assign free_total_o  = free_total_q;
  assign bytes_total_o = bytes_total_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Allocation tracking table - testbench
// Drives allocate, free, bucket read and clear commands into the table and
// checks every result beat against a local model of the table and counters.
// ----------------------------------------------------------------------------
module tb;
  import att_pkg::*;

  localparam int unsigned NSETS = 256;
  localparam int unsigned NWAYS = 4;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] live_count;
    logic [47:0] live_bytes;
    logic [31:0] peak_count;
    logic [47:0] peak_bytes;
    logic [31:0] alloc_total;
    logic [31:0] free_total;
    logic [47:0] bytes_total;
    logic [31:0] bucket_count;
    logic [47:0] bucket_bytes;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = '0;
  logic [47:0] address_i = '0;
  logic [39:0] alloc_size_i = '0;
  logic [4:0] bucket_select_i = '0;
  logic done_o;
  logic [2:0] status_o;
  logic [31:0] live_count_o, peak_count_o, alloc_total_o, free_total_o, bucket_count_o;
  logic [47:0] live_bytes_o, peak_bytes_o, bytes_total_o, bucket_bytes_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [39:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  allocation_tracking_table u_dut (.*);

  // model state
  logic [47:0] tbl_addr [NSETS*NWAYS];
  logic [39:0] tbl_size [NSETS*NWAYS];
  bit          tbl_valid[NSETS*NWAYS];
  logic [31:0] m_live_cnt, m_peak_cnt, m_alloc_tot, m_free_tot;
  logic [47:0] m_live_bytes, m_peak_bytes, m_bytes_tot;
  logic [31:0] hist_cnt [NBUCKETS];
  logic [47:0] hist_bytes[NBUCKETS];
  bit          m_enable;
  logic [39:0] m_min_size;

  stats_t      expected_q[$];
  logic [47:0] live_addrs[$];
  int          n_errors = 0;
  int          n_results = 0;
  int          send_gap_pct = 0;

  function automatic logic [31:0] add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic logic [47:0] add48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = a + b;
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic int size_bucket(logic [39:0] sz);
    int k;
    k = 0;
    if (sz < 64) return 0;
    for (int i = 0; i < 40; i++) if (sz[i]) k = i;
    k -= 5;
    return (k > 26) ? 26 : k;
  endfunction

  function automatic int set_index(logic [47:0] a);
    logic [47:0] h;
    h = a ^ (a >> 16);
    return int'(h[7:0]);
  endfunction

  function automatic void zero_stats();
    m_live_cnt = '0; m_live_bytes = '0; m_peak_cnt = '0; m_peak_bytes = '0;
    m_alloc_tot = '0; m_free_tot = '0; m_bytes_tot = '0;
    for (int b = 0; b < NBUCKETS; b++) begin
      hist_cnt[b] = '0;
      hist_bytes[b] = '0;
    end
  endfunction

  // predict one result from the table model
  function automatic stats_t table_predict(action_e act, logic [47:0] a,
                                           logic [39:0] sz, logic [4:0] sel);
    stats_t r;
    int base, hit, fw, b;
    base = set_index(a) * NWAYS;
    hit = -1;
    fw = -1;
    r = '0;
    for (int w = 0; w < NWAYS; w++) begin
      if (tbl_valid[base+w]) begin
        if (hit < 0 && tbl_addr[base+w] == a) hit = base + w;
      end else if (fw < 0) fw = base + w;
    end
    case (act)
      ACT_ALLOC: begin
        if (!m_enable) r.status = STS_DISABLED;
        else if (a == 0) r.status = STS_NULL;
        else if (sz < m_min_size) r.status = STS_BELOW_MIN;
        else if (hit >= 0) r.status = STS_DUPLICATE;
        else if (fw < 0) r.status = STS_FULL;
        else begin
          r.status = STS_OK;
          b = size_bucket(sz);
          tbl_addr[fw] = a;
          tbl_size[fw] = sz;
          tbl_valid[fw] = 1;
          live_addrs.push_back(a);
          m_alloc_tot = add32(m_alloc_tot, 1);
          m_live_cnt = add32(m_live_cnt, 1);
          m_bytes_tot = add48(m_bytes_tot, 48'(sz));
          m_live_bytes = add48(m_live_bytes, 48'(sz));
          if (m_live_cnt > m_peak_cnt) m_peak_cnt = m_live_cnt;
          if (m_live_bytes > m_peak_bytes) m_peak_bytes = m_live_bytes;
          hist_cnt[b] = add32(hist_cnt[b], 1);
          hist_bytes[b] = add48(hist_bytes[b], 48'(sz));
        end
      end
      ACT_FREE: begin
        if (!m_enable) r.status = STS_DISABLED;
        else if (a == 0) r.status = STS_NULL;
        else if (hit < 0) r.status = STS_NOT_TRACKED;
        else begin
          r.status = STS_OK;
          tbl_valid[hit] = 0;
          foreach (live_addrs[i]) if (live_addrs[i] == a) begin
            live_addrs.delete(i);
            break;
          end
          m_free_tot = add32(m_free_tot, 1);
          m_live_cnt = (m_live_cnt == 0) ? '0 : m_live_cnt - 1;
          m_live_bytes = (48'(tbl_size[hit]) > m_live_bytes) ? '0
                         : m_live_bytes - 48'(tbl_size[hit]);
        end
      end
      ACT_READ: begin
        r.status = STS_OK;
        if (sel < NBUCKETS) begin
          r.bucket_count = hist_cnt[sel];
          r.bucket_bytes = hist_bytes[sel];
        end
      end
      default: begin
        r.status = STS_OK;
        zero_stats();
      end
    endcase
    r.live_count = m_live_cnt; r.live_bytes = m_live_bytes;
    r.peak_count = m_peak_cnt; r.peak_bytes = m_peak_bytes;
    r.alloc_total = m_alloc_tot; r.free_total = m_free_tot;
    r.bytes_total = m_bytes_tot;
    return r;
  endfunction

  // send one command beat, predicting its result on acceptance;
  // start stays high after acceptance, the block is busy at the next edge
  task automatic issue(action_e act, logic [47:0] a, logic [39:0] sz, logic [4:0] sel);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    address_i <= a;
    alloc_size_i <= sz;
    bucket_select_i <= sel;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(table_predict(act, a, sz, sel));
  endtask

  task automatic write_reg(logic idx, logic [39:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_ENABLE) m_enable = val[0];
    else m_min_size = val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); n_errors++; end
        if (live_count_o !== e.live_count) begin
          $error("live_count exp %0d got %0d", e.live_count, live_count_o); n_errors++; end
        if (live_bytes_o !== e.live_bytes) begin
          $error("live_bytes exp %0d got %0d", e.live_bytes, live_bytes_o); n_errors++; end
        if (peak_count_o !== e.peak_count) begin
          $error("peak_count exp %0d got %0d", e.peak_count, peak_count_o); n_errors++; end
        if (peak_bytes_o !== e.peak_bytes) begin
          $error("peak_bytes exp %0d got %0d", e.peak_bytes, peak_bytes_o); n_errors++; end
        if (alloc_total_o !== e.alloc_total) begin
          $error("alloc_total exp %0d got %0d", e.alloc_total, alloc_total_o); n_errors++; end
        if (free_total_o !== e.free_total) begin
          $error("free_total exp %0d got %0d", e.free_total, free_total_o); n_errors++; end
        if (bytes_total_o !== e.bytes_total) begin
          $error("bytes_total exp %0d got %0d", e.bytes_total, bytes_total_o); n_errors++; end
        if (bucket_count_o !== e.bucket_count) begin
          $error("bucket_count exp %0d got %0d", e.bucket_count, bucket_count_o);
          n_errors++;
        end
        if (bucket_bytes_o !== e.bucket_bytes) begin
          $error("bucket_bytes exp %0d got %0d", e.bucket_bytes, bucket_bytes_o);
          n_errors++;
        end
      end
    end
  end

  // directed: every rejection path, extremes and bucket edges
  task automatic test_directed();
    logic [47:0] a;
    issue(ACT_ALLOC, 48'h1000, 40'd100, 5'd0);       // disabled
    issue(ACT_FREE, 48'h1000, 40'd0, 5'd0);          // disabled
    issue(ACT_READ, 48'h0, 40'd0, 5'd31);            // read while disabled
    drain();
    write_reg(CFG_ENABLE, 40'd1);
    write_reg(CFG_MIN_SIZE, 40'd0);
    issue(ACT_ALLOC, 48'h0, 40'd8, 5'd0);            // null
    issue(ACT_FREE, 48'h0, 40'd0, 5'd0);             // null free
    issue(ACT_ALLOC, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 5'd0);
    issue(ACT_ALLOC, 48'h1, 40'd0, 5'd0);
    issue(ACT_ALLOC, 48'h40, 40'd63, 5'd0);
    issue(ACT_ALLOC, 48'h80, 40'd64, 5'd0);
    issue(ACT_ALLOC, 48'hC0, 40'd2147483648, 5'd0);
    issue(ACT_ALLOC, 48'h80, 40'd5, 5'd0);           // already tracked
    // fill one set: same low hash, different upper bits
    for (int i = 1; i <= 5; i++) begin
      a = {16'(i), 16'(i), 16'h0123};
      issue(ACT_ALLOC, a ^ {32'h0, 16'(i)}, 40'd4096, 5'd0);
    end
    issue(ACT_FREE, 48'h9999, 40'd0, 5'd0);          // not tracked
    issue(ACT_READ, 48'h0, 40'd0, 5'd26);
    issue(ACT_READ, 48'h0, 40'd0, 5'd0);
    issue(ACT_CLEAR, 48'h0, 40'd0, 5'd0);
    issue(ACT_FREE, 48'hFFFF_FFFF_FFFF, 40'd0, 5'd0); // free after clear floors at zero
    issue(ACT_FREE, 48'h80, 40'd0, 5'd0);
    drain();
    write_reg(CFG_MIN_SIZE, 40'hFF_FFFF_FFFF);
    issue(ACT_ALLOC, 48'h2222, 40'hFF_FFFF_FFFE, 5'd0); // below minimum
    issue(ACT_FREE, 48'h40, 40'd0, 5'd0);            // free ignores min_size
    drain();
  endtask

  function automatic logic [39:0] rand_size();
    int sh;
    sh = $urandom_range(39);
    return 40'({$urandom, $urandom} >> (63 - sh));
  endfunction

  function automatic logic [47:0] rand_addr();
    // small pool so sets fill and duplicates occur; sometimes fully random
    if ($urandom_range(9) == 0) return 48'({$urandom, $urandom});
    return {16'($urandom_range(3)) << 14, 16'($urandom_range(7)), 16'($urandom_range(300))};
  endfunction

  task automatic test_random(int n);
    int p;
    logic [47:0] a;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 45) issue(ACT_ALLOC, rand_addr(), rand_size(), 5'($urandom));
      else if (p < 80) begin
        if (live_addrs.size() != 0 && $urandom_range(3) != 0)
          a = live_addrs[$urandom_range(live_addrs.size() - 1)];
        else a = rand_addr();
        issue(ACT_FREE, a, rand_size(), 5'($urandom));
      end else if (p < 97) begin
        issue(ACT_READ, 48'({$urandom, $urandom}), rand_size(), 5'($urandom));
      end else begin
        issue(ACT_CLEAR, 48'({$urandom, $urandom}), rand_size(), 5'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    foreach (tbl_valid[i]) tbl_valid[i] = 0;
    zero_stats();
    m_enable = 0;
    m_min_size = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    write_reg(CFG_MIN_SIZE, 40'd0);
    send_gap_pct = 30;
    test_random(500);
    write_reg(CFG_MIN_SIZE, 40'd100);
    write_reg(CFG_ENABLE, 40'd0);
    send_gap_pct = 83;
    test_random(50);
    write_reg(CFG_ENABLE, 40'd1);
    test_random(500);
    write_reg(CFG_MIN_SIZE, 40'd0);
    send_gap_pct = 0;
    test_random(500);
    $display("covered %0d result beats: all actions, rejections, set overflow,",
             n_results);
    $display("bucket reads incl. out of range, clears and min_size/enable settings");
    if (n_errors == 0) $display("allocation_tracking_table verification clean");
    else $display("allocation_tracking_table verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("allocation_tracking_table verification failed");
    $finish;
  end

endmodule
